// File: rtl/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg: shared types and constants of the constraint graph colorer
// Sizes of the color space, slot tables and body masks, operation codes,
// sequencer states and the slot table address helper.
// ----------------------------------------------------------------------------
package cgc_pkg;

	// Sizes
	localparam int BODY_COUNT      = 4096;
	localparam int STATIC_COLORS   = 4;
	localparam int DYNAMIC_COLORS  = 12;
	localparam int SLOTS_PER_COLOR = 1024;
	localparam int HANDLE_BITS     = 16;

	localparam int SERIAL_COLOR = STATIC_COLORS + DYNAMIC_COLORS;
	localparam int COLOR_TOTAL  = SERIAL_COLOR + 1;
	localparam int TABLE_DEPTH  = COLOR_TOTAL * SLOTS_PER_COLOR;
	localparam int TBL_AW       = $clog2(TABLE_DEPTH);
	localparam int MASK_W       = SERIAL_COLOR;
	localparam int CNT_W        = $clog2(SLOTS_PER_COLOR + 1);

	// Field widths of the stream items
	localparam int BODY_W  = 12;
	localparam int COLOR_W = 5;
	localparam int SLOT_W  = 10;
	localparam int IN_TDATA_W  = 64;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 40;

	// Color ranges searched by the first-free search
	localparam logic [MASK_W-1:0] STATIC_RANGE =
		MASK_W'((64'd1 << STATIC_COLORS) - 64'd1);
	localparam logic [MASK_W-1:0] DYNAMIC_RANGE = ~STATIC_RANGE;

	// Operation codes
	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FLUSH  = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_SECOND,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH_MARK,
		ST_RESULT
	} state_t;

	// Slot table address of one slot within one color
	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [COLOR_W-1:0] color,
		input logic [SLOT_W-1:0] slot);
		return TBL_AW'(color) * TBL_AW'(SLOTS_PER_COLOR) + TBL_AW'(slot);
	endfunction

endpackage

// File: rtl/cgc_ram.sv
// ----------------------------------------------------------------------------
// cgc_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cgc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/constraint_graph_colorer.sv
// ----------------------------------------------------------------------------
// constraint_graph_colorer: greedy color assignment for body constraints
// Add runs through read second, decide, update, finish mark and result; remove
// skips finish mark; a refused request reaches result early (unused kind from idle,
// static pair from decide, full table from update). The next transaction is taken
// once the sequencer is back in idle, so a new item waits until the last is done.
// Flush sweeps the body mask RAM, one body a cycle, then returns its result.
// After reset the same sweep runs before the first transaction.
// ----------------------------------------------------------------------------
module constraint_graph_colorer
	import cgc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [11:0] body_first, [23:12] body_second, [24] first_dynamic,
	// [25] second_dynamic, [41:26] constraint_handle, [46:42] old_color,
	// [56:47] old_slot, rest zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [1:0] kind, [2] is_contact
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [4:0] new_color, [14:5] new_slot, [15] moved_valid, [31:16] moved_handle,
	// [32] error_flag, rest zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	state_t state_q, state_d;

	// Latched transaction
	kind_t                   kind_q;
	logic                    contact_q;
	logic [BODY_W-1:0]       b0_q, b1_q;
	logic                    d0_q, d1_q;
	logic [HANDLE_BITS-1:0]  handle_q;
	logic [COLOR_W-1:0]      color_q;
	logic [SLOT_W-1:0]       oslot_q;
	logic [MASK_W-1:0]       m0_q, m1_q;

	// Result fields
	logic [COLOR_W-1:0]      res_color_q;
	logic [SLOT_W-1:0]       res_slot_q;
	logic                    res_mv_q;
	logic [HANDLE_BITS-1:0]  res_mh_q;
	logic                    res_err_q;

	// Control
	logic                    flush_q;
	logic [BODY_W-1:0]       sweep_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic [CNT_W-1:0]        jcnt_q [COLOR_TOTAL];
	logic [CNT_W-1:0]        ccnt_q [COLOR_TOTAL];

	// Memory ports
	logic                    mask_we;
	logic [BODY_W-1:0]       mask_waddr, mask_raddr;
	logic [MASK_W-1:0]       mask_wdata, mask_rdata;
	logic                    jtbl_we, ctbl_we;
	logic [TBL_AW-1:0]       tbl_waddr, tbl_raddr;
	logic [HANDLE_BITS-1:0]  tbl_wdata, jtbl_rdata, ctbl_rdata, tbl_rdata;

	// Datapath
	logic                    accept, out_free, color_ok, marks_on;
	logic [CNT_W-1:0]        cnt_rd, cnt_last;
	logic [MASK_W-1:0]       used, cand, lowest, color_bit;
	logic [COLOR_W-1:0]      found_color;
	logic                    add_err, rem_err, table_full, do_move;
	kind_t                   in_kind;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign in_kind  = kind_t'(s_tuser[1:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Body color masks
	cgc_ram #(.WIDTH(MASK_W), .DEPTH(BODY_COUNT)) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.raddr (mask_raddr),
		.rdata (mask_rdata)
	);

	// Joint slot table
	cgc_ram #(.WIDTH(HANDLE_BITS), .DEPTH(TABLE_DEPTH)) u_joint_ram (
		.clk   (clk),
		.we    (jtbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (jtbl_rdata)
	);

	// Contact slot table
	cgc_ram #(.WIDTH(HANDLE_BITS), .DEPTH(TABLE_DEPTH)) u_contact_ram (
		.clk   (clk),
		.we    (ctbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (ctbl_rdata)
	);

	assign tbl_rdata = contact_q ? ctbl_rdata : jtbl_rdata;

	// Count lookup, checks and first-free search
	always_comb begin
		color_ok = (color_q <= COLOR_W'(SERIAL_COLOR));
		marks_on = (color_q < COLOR_W'(SERIAL_COLOR));
		cnt_rd   = '0;
		if (color_ok) begin
			cnt_rd = contact_q ? ccnt_q[color_q] : jcnt_q[color_q];
		end
		cnt_last   = cnt_rd - CNT_W'(1);
		table_full = (cnt_rd >= CNT_W'(SLOTS_PER_COLOR));
		rem_err    = !color_ok || (CNT_W'(oslot_q) >= cnt_rd);
		do_move    = (CNT_W'(oslot_q) < cnt_last);
		add_err    = !d0_q && !d1_q;
		color_bit  = marks_on ? (MASK_W'(1) << color_q) : '0;

		// mask_rdata holds the second body's mask in the decide state
		if (d0_q && d1_q) begin
			used = m0_q | mask_rdata;
			cand = ~used & DYNAMIC_RANGE;
		end else begin
			used = d1_q ? mask_rdata : m0_q;
			cand = ~used & STATIC_RANGE;
		end
		lowest      = cand & (~cand + MASK_W'(1));
		found_color = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (lowest[i]) begin
				found_color = found_color | COLOR_W'(i);
			end
		end
		if (cand == '0) begin
			found_color = COLOR_W'(SERIAL_COLOR);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_q == BODY_W'(BODY_COUNT - 1)) begin
					state_d = flush_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_ADD, KIND_REMOVE: state_d = ST_READ_SECOND;
						KIND_FLUSH:            state_d = ST_CLEAR;
						default:               state_d = ST_RESULT;
					endcase
				end
			end
			ST_READ_SECOND: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (kind_q == KIND_ADD) begin
					state_d = add_err ? ST_RESULT : ST_UPDATE;
				end else begin
					state_d = rem_err ? ST_RESULT : ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (kind_q == KIND_ADD && !table_full) begin
					state_d = ST_FINISH_MARK;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_FINISH_MARK: state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		mask_we    = 1'b0;
		mask_waddr = b0_q;
		mask_wdata = m0_q;
		mask_raddr = b1_q;
		jtbl_we    = 1'b0;
		ctbl_we    = 1'b0;
		tbl_waddr  = tbl_addr(color_q, cnt_rd[SLOT_W-1:0]);
		tbl_wdata  = handle_q;
		tbl_raddr  = tbl_addr(color_q, cnt_last[SLOT_W-1:0]);
		case (state_q)
			ST_CLEAR: begin
				mask_we    = 1'b1;
				mask_waddr = sweep_q;
				mask_wdata = '0;
			end
			ST_IDLE: begin
				mask_raddr = s_tdata[BODY_W-1:0];
			end
			ST_DECIDE: begin
				// remove: clear the first body's mark
				if (kind_q == KIND_REMOVE && !rem_err && marks_on) begin
					mask_we    = 1'b1;
					mask_waddr = b0_q;
					mask_wdata = m0_q & ~color_bit;
				end
			end
			ST_UPDATE: begin
				if (kind_q == KIND_ADD) begin
					if (!table_full) begin
						mask_we    = d0_q && marks_on;
						mask_waddr = b0_q;
						mask_wdata = m0_q | color_bit;
						jtbl_we    = !contact_q;
						ctbl_we    = contact_q;
					end
				end else begin
					// remove: clear the second mark, fill the hole from the last slot
					mask_we    = marks_on;
					mask_waddr = b1_q;
					mask_wdata = m1_q & ~color_bit;
					tbl_waddr  = tbl_addr(color_q, oslot_q);
					tbl_wdata  = tbl_rdata;
					jtbl_we    = do_move && !contact_q;
					ctbl_we    = do_move && contact_q;
				end
			end
			ST_FINISH_MARK: begin
				mask_we    = d1_q && marks_on;
				mask_waddr = b1_q;
				mask_wdata = m1_q | color_bit;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			flush_q    <= 1'b0;
			sweep_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int c = 0; c < COLOR_TOTAL; c++) begin
				jcnt_q[c] <= '0;
				ccnt_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;

			// Advance the clearing sweep
			if (state_q == ST_CLEAR) begin
				sweep_q <= sweep_q + BODY_W'(1);
			end

			// Flush: drop all counts and start the sweep
			if (state_q == ST_IDLE && accept && in_kind == KIND_FLUSH) begin
				flush_q <= 1'b1;
				sweep_q <= '0;
				for (int c = 0; c < COLOR_TOTAL; c++) begin
					jcnt_q[c] <= '0;
					ccnt_q[c] <= '0;
				end
			end

			// Update the count of the chosen color
			if (state_q == ST_UPDATE) begin
				if (kind_q == KIND_ADD) begin
					if (!table_full) begin
						if (contact_q) begin
							ccnt_q[color_q] <= cnt_rd + CNT_W'(1);
						end else begin
							jcnt_q[color_q] <= cnt_rd + CNT_W'(1);
						end
					end
				end else begin
					if (contact_q) begin
						ccnt_q[color_q] <= cnt_last;
					end else begin
						jcnt_q[color_q] <= cnt_last;
					end
				end
			end

			// Output register
			if (state_q == ST_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
				flush_q    <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q      <= in_kind;
					contact_q   <= s_tuser[2];
					b0_q        <= s_tdata[11:0];
					b1_q        <= s_tdata[23:12];
					d0_q        <= s_tdata[24];
					d1_q        <= s_tdata[25];
					handle_q    <= s_tdata[41:26];
					color_q     <= s_tdata[46:42];
					oslot_q     <= s_tdata[56:47];
					res_color_q <= '0;
					res_slot_q  <= '0;
					res_mv_q    <= 1'b0;
					res_mh_q    <= '0;
					res_err_q   <= (in_kind == KIND_UNUSED);
				end
			end
			ST_READ_SECOND: begin
				m0_q <= mask_rdata;
			end
			ST_DECIDE: begin
				m1_q <= mask_rdata;
				if (kind_q == KIND_ADD) begin
					color_q   <= found_color;
					res_err_q <= add_err;
				end else begin
					res_err_q <= rem_err;
				end
			end
			ST_UPDATE: begin
				if (kind_q == KIND_ADD) begin
					if (table_full) begin
						res_err_q <= 1'b1;
					end else begin
						res_color_q <= color_q;
						res_slot_q  <= cnt_rd[SLOT_W-1:0];
					end
				end else if (do_move) begin
					res_mv_q <= 1'b1;
					res_mh_q <= tbl_rdata;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					m_tdata_q <= {7'd0, res_err_q, res_mh_q, res_mv_q, res_slot_q, res_color_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
